// ----- rtl/core/qes_pkg.sv -----
`default_nettype none
package qes_pkg;
  localparam int CoordW = 32;
  localparam int EdgeW = 33;
  localparam int AngW = 32;
  localparam int SkewW = 16;
  localparam int NumLanes = 4;
  localparam int TabDepth = 32;
  localparam logic [AngW-1:0] Quarter = 32'h4000_0000;
  localparam logic [AngW-1:0] Half = 32'h8000_0000;
  localparam logic [AngW-1:0] ThreeQuarter = 32'hC000_0000;

  typedef logic [AngW-1:0] ang_t;

  typedef struct packed {
    logic vld;
    logic planar;
    logic degen;
  } ctl_t;

  function automatic ang_t atan_lookup(input logic [4:0] k);
    ang_t r;
    unique case (k)
      5'd0: r = 32'd536870912;
      5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;
      5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;
      5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;
      5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;
      5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/qes_cordic_lane.sv -----
`default_nettype none
module qes_cordic_lane import qes_pkg::*; #(
  parameter int STEPS = 16
) (
  input  wire logic                    clk,
  input  wire logic signed [EdgeW-1:0] ex,
  input  wire logic signed [EdgeW-1:0] ey,
  output ang_t                         dir
);
  localparam int XW = EdgeW + 3;

  logic signed [XW-1:0] x_r [STEPS+1];
  logic signed [XW-1:0] y_r [STEPS+1];
  ang_t                 z_r [STEPS+1];

  always_ff @(posedge clk) begin
    if (ex < 0) begin
      if (ey >= 0) begin
        x_r[0] <= XW'(ey);
        y_r[0] <= -XW'(ex);
        z_r[0] <= Quarter;
      end else begin
        x_r[0] <= -XW'(ey);
        y_r[0] <= XW'(ex);
        z_r[0] <= ThreeQuarter;
      end
    end else begin
      x_r[0] <= XW'(ex);
      y_r[0] <= XW'(ey);
      z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    localparam logic [4:0] K = 5'(i % TabDepth);
    logic signed [XW-1:0] dx, dy;
    assign dx = y_r[i] >>> K;
    assign dy = x_r[i] >>> K;
    always_ff @(posedge clk) begin
      if (y_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
        z_r[i+1] <= z_r[i] + atan_lookup(K);
      end else begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
        z_r[i+1] <= z_r[i] - atan_lookup(K);
      end
    end
  end

  assign dir = z_r[STEPS];
endmodule
`default_nettype wire

// ----- rtl/core/qes_merge.sv -----
`default_nettype none
module qes_merge import qes_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ctl_t             ctl,
  input  wire ang_t             dir [NumLanes],
  output logic                  out_strobe,
  output logic [SkewW-1:0]      out_skew,
  output logic                  out_degenerate
);
  function automatic ang_t corner(input ang_t a, input ang_t b);
    ang_t d;
    d = a - b;
    if (d > Half) d = -d;
    return d;
  endfunction

  ang_t ang_r [NumLanes];
  ctl_t c1_r, c2_r;
  ang_t mn_r, mx_r;
  ang_t mn01, mn23, mx01, mx23;
  logic [AngW:0] s1, s2, s;
  logic [AngW:0] q;
  logic [SkewW-1:0] skew_nxt;

  always_ff @(posedge clk) begin
    ang_r[0] <= corner(dir[0], dir[3] + Half);
    ang_r[1] <= corner(dir[0] + Half, dir[1]);
    ang_r[2] <= corner(dir[1] + Half, dir[2]);
    ang_r[3] <= corner(dir[2] + Half, dir[3]);
    mn_r <= (mn01 < mn23) ? mn01 : mn23;
    mx_r <= (mx01 > mx23) ? mx01 : mx23;
  end

  assign mn01 = (ang_r[1] < ang_r[0]) ? ang_r[1] : ang_r[0];
  assign mn23 = (ang_r[3] < ang_r[2]) ? ang_r[3] : ang_r[2];
  assign mx01 = (ang_r[1] > ang_r[0]) ? ang_r[1] : ang_r[0];
  assign mx23 = (ang_r[3] > ang_r[2]) ? ang_r[3] : ang_r[2];

  always_comb begin
    s1 = (mx_r > Quarter) ? {1'b0, mx_r - Quarter} : '0;
    s2 = (mn_r < Quarter) ? {1'b0, Quarter - mn_r} : '0;
    s = (s1 > s2) ? s1 : s2;
    q = (s + (AngW+1)'(16'h4000)) >> 15;
    if (q > (AngW+1)'(32768)) skew_nxt = 16'd32768;
    else skew_nxt = q[SkewW-1:0];
    if (!c2_r.planar || c2_r.degen) skew_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      out_strobe <= 1'b0;
    end else begin
      c1_r <= ctl;
      c2_r <= c1_r;
      out_strobe <= c2_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_skew <= skew_nxt;
    out_degenerate <= c2_r.planar & c2_r.degen;
  end
endmodule
`default_nettype wire

// ----- rtl/core/quad_equiangle_skewness.sv -----
// Equiangle skewness of a planar quad, one request per clock, fully pipelined:
// busy is always low. Four CORDIC lanes (one per edge, CORDIC_STEPS+1 stages)
// feed a three-stage angle merge whose last stage registers the result and its strobe.
// Results cannot be held off by the receiver. cfg is always ready; write
// planar_mode only when no request is in flight.
`default_nettype none
module quad_equiangle_skewness import qes_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [CoordW-1:0] in_ll_x,
  input  wire logic [CoordW-1:0] in_ll_y,
  input  wire logic [CoordW-1:0] in_lr_x,
  input  wire logic [CoordW-1:0] in_lr_y,
  input  wire logic [CoordW-1:0] in_tl_x,
  input  wire logic [CoordW-1:0] in_tl_y,
  input  wire logic [CoordW-1:0] in_tr_x,
  input  wire logic [CoordW-1:0] in_tr_y,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_planar_mode,
  output logic                   out_strobe,
  output logic [SkewW-1:0]       out_skew,
  output logic                   out_degenerate
);
  logic planar_r;
  logic signed [EdgeW-1:0] ex_r [NumLanes];
  logic signed [EdgeW-1:0] ey_r [NumLanes];
  ctl_t ctl_r [CORDIC_STEPS+2];
  ctl_t in_ctl;
  ang_t dir [NumLanes];
  logic signed [EdgeW-1:0] ex_nxt [NumLanes];
  logic signed [EdgeW-1:0] ey_nxt [NumLanes];
  logic degen_nxt;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  function automatic logic signed [EdgeW-1:0] dif(input logic [CoordW-1:0] a,
                                                  input logic [CoordW-1:0] b);
    return $signed({a[CoordW-1], a}) - $signed({b[CoordW-1], b});
  endfunction

  always_comb begin
    ex_nxt[0] = dif(in_lr_x, in_ll_x); ey_nxt[0] = dif(in_lr_y, in_ll_y);
    ex_nxt[1] = dif(in_tr_x, in_lr_x); ey_nxt[1] = dif(in_tr_y, in_lr_y);
    ex_nxt[2] = dif(in_tl_x, in_tr_x); ey_nxt[2] = dif(in_tl_y, in_tr_y);
    ex_nxt[3] = dif(in_ll_x, in_tl_x); ey_nxt[3] = dif(in_ll_y, in_tl_y);
    degen_nxt = 1'b0;
    for (int k = 0; k < NumLanes; k++)
      if (ex_nxt[k] == '0 && ey_nxt[k] == '0) degen_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      planar_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      planar_r <= cfg_planar_mode;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NumLanes; k++) begin
      ex_r[k] <= ex_nxt[k];
      ey_r[k] <= ey_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CORDIC_STEPS+2; i++) ctl_r[i] <= '0;
    end else begin
      ctl_r[0] <= '{vld: start & ~busy, planar: planar_r, degen: degen_nxt};
      for (int i = 1; i < CORDIC_STEPS+2; i++) ctl_r[i] <= ctl_r[i-1];
    end
  end

  for (genvar k = 0; k < NumLanes; k++) begin : g_lane
    qes_cordic_lane #(.STEPS(CORDIC_STEPS)) u_lane (
      .clk (clk),
      .ex  (ex_r[k]),
      .ey  (ey_r[k]),
      .dir (dir[k])
    );
  end

  assign in_ctl = ctl_r[CORDIC_STEPS+1];

  qes_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (in_ctl),
    .dir            (dir),
    .out_strobe     (out_strobe),
    .out_skew       (out_skew),
    .out_degenerate (out_degenerate)
  );
endmodule
`default_nettype wire

// ----- rtl/core/qes_checker.sv -----
`default_nettype none
module qes_checker import qes_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             busy,
  input wire logic             out_strobe,
  input wire logic [SkewW-1:0] out_skew,
  input wire logic             out_degenerate
);
  a_skew_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_skew <= 16'd32768) else $error("skew out of range");
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_degenerate |-> out_skew == '0) else $error("degenerate skew");
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy) else $error("busy raised");
endmodule

bind quad_equiangle_skewness qes_checker u_qes_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_skew       (out_skew),
  .out_degenerate (out_degenerate)
);
`default_nettype wire
